// ===== rtl/core/rlpan_pkg.sv =====
// shared types and constants for the rlp address/nonce list encoder
// used by every file under rtl/core; no dependencies
`default_nettype none
package rlpan_pkg;

  localparam int EncBytes   = 31;            // longest encoding of one item
  localparam int EncBits    = EncBytes * 8;
  localparam int CntW       = $clog2(EncBytes + 1);
  localparam int QueueDepth = 2;
  localparam int QPtrW      = $clog2(QueueDepth);
  localparam int QCntW      = $clog2(QueueDepth + 1);

  localparam logic [7:0] StrBase    = 8'h80;
  localparam logic [7:0] ListBase   = 8'hc0;
  localparam logic [7:0] AddrPrefix = 8'h94;
  localparam logic [7:0] FixedLen   = 8'd21;  // address prefix + 20 address bytes

  // one classified item: the whole encoding, left aligned, and its length
  typedef struct packed {
    logic [EncBits-1:0] bytes;
    logic [CntW-1:0]    total;
  } enc_item_t;

  typedef struct packed {
    logic empty;
    logic full;
  } q_status_t;

endpackage
`default_nettype wire

// ===== rtl/core/rlpan_front.sv =====
// front part: classifies the nonce and lays out the full byte string of an item
// depends on rlpan_pkg
`default_nettype none
module rlpan_front (
  input  wire logic [31:0]         sender_top,
  input  wire logic [63:0]         sender_middle,
  input  wire logic [63:0]         sender_bottom,
  input  wire logic [63:0]         nonce_value,
  output rlpan_pkg::enc_item_t     item
);

  logic [3:0]  nbytes;
  logic [3:0]  nlen;
  logic [5:0]  shamt;
  logic [63:0] nonce_al;
  logic [71:0] nenc;
  logic [7:0]  list_hdr;

  // significant byte count of the nonce
  always_comb begin
    nbytes = 4'd0;
    for (int i = 0; i < 8; i++) begin
      if (nonce_value[i*8 +: 8] != 8'h00) begin
        nbytes = 4'(i + 1);
      end
    end
  end

  assign shamt    = {(3'd0 - nbytes[2:0]), 3'b000}; // 8 * (8 - n), n = 8 gives 0
  assign nonce_al = nonce_value << shamt;

  always_comb begin
    if (nonce_value == 64'd0) begin
      nenc = {rlpan_pkg::StrBase, 64'd0};
      nlen = 4'd1;
    end else if (nonce_value[63:7] == 57'd0) begin
      nenc = {nonce_value[7:0], 64'd0};
      nlen = 4'd1;
    end else begin
      nenc = {rlpan_pkg::StrBase + {4'd0, nbytes}, nonce_al};
      nlen = nbytes + 4'd1;
    end
  end

  assign list_hdr = rlpan_pkg::ListBase + rlpan_pkg::FixedLen + {4'd0, nlen};

  assign item.bytes = {list_hdr, rlpan_pkg::AddrPrefix,
                       sender_top, sender_middle, sender_bottom, nenc};
  assign item.total = rlpan_pkg::CntW'(5'd22 + {1'b0, nlen});

endmodule
`default_nettype wire

// ===== rtl/core/rlpan_queue.sv =====
// short queue of classified items between front and back
// depends on rlpan_pkg
`default_nettype none
module rlpan_queue (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 wr_en,
  input  wire rlpan_pkg::enc_item_t wr_item,
  input  wire logic                 rd_en,
  output rlpan_pkg::enc_item_t      rd_item,
  output rlpan_pkg::q_status_t      status
);

  rlpan_pkg::enc_item_t            mem_r [rlpan_pkg::QueueDepth];
  logic [rlpan_pkg::QPtrW-1:0]     wr_ptr_r, wr_ptr_nxt;
  logic [rlpan_pkg::QPtrW-1:0]     rd_ptr_r, rd_ptr_nxt;
  logic [rlpan_pkg::QCntW-1:0]     cnt_r, cnt_nxt;
  logic                            do_wr, do_rd;

  assign status.empty = (cnt_r == '0);
  assign status.full  = (cnt_r == rlpan_pkg::QCntW'(rlpan_pkg::QueueDepth));
  assign do_wr = wr_en && !status.full;
  assign do_rd = rd_en && !status.empty;
  assign rd_item = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_wr) begin
      wr_ptr_nxt = (wr_ptr_r == rlpan_pkg::QPtrW'(rlpan_pkg::QueueDepth - 1)) ?
                   '0 : wr_ptr_r + 1'b1;
    end
    if (do_rd) begin
      rd_ptr_nxt = (rd_ptr_r == rlpan_pkg::QPtrW'(rlpan_pkg::QueueDepth - 1)) ?
                   '0 : rd_ptr_r + 1'b1;
    end
    if (do_wr && !do_rd) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_rd && !do_wr) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem_r[wr_ptr_r] <= wr_item;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/rlpan_back.sv =====
// back part: shifts one item's encoding out a byte at a time
// depends on rlpan_pkg
`default_nettype none
module rlpan_back (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire rlpan_pkg::enc_item_t q_item,
  input  wire rlpan_pkg::q_status_t q_status,
  output logic                      q_rd,
  output logic                      empty,
  input  wire logic                 pop,
  output logic [7:0]                out_byte,
  output logic                      out_last_byte
);

  logic [rlpan_pkg::EncBits-1:0] shift_r, shift_nxt;
  logic [rlpan_pkg::CntW-1:0]    remain_r, remain_nxt;
  logic                          busy, taken, need;

  assign busy          = (remain_r != '0);
  assign empty         = !busy;
  assign out_byte      = shift_r[rlpan_pkg::EncBits-1 -: 8];
  assign out_last_byte = (remain_r == rlpan_pkg::CntW'(1));
  assign taken         = pop && busy;
  // reload when idle or as the last byte leaves
  assign need          = !busy || (taken && out_last_byte);
  assign q_rd          = need && !q_status.empty;

  always_comb begin
    shift_nxt  = shift_r;
    remain_nxt = remain_r;
    if (q_rd) begin
      shift_nxt  = q_item.bytes;
      remain_nxt = q_item.total;
    end else if (taken) begin
      shift_nxt  = {shift_r[rlpan_pkg::EncBits-9:0], 8'h00};
      remain_nxt = remain_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      remain_r <= '0;
    end else begin
      remain_r <= remain_nxt;
    end
  end

  always_ff @(posedge clk) begin
    shift_r <= shift_nxt;
  end

endmodule
`default_nettype wire

// ===== rtl/core/rlp_address_nonce_encoder_core.sv =====
// top level of the rlp encoder for the list [sender, nonce]
// depends on rlpan_pkg, rlpan_front, rlpan_queue, rlpan_back
`default_nettype none
// Usage:
//   input queue side: drive the sender address (top/middle/bottom words) and
//   the nonce with push high; the item is taken on a clock edge where full
//   is low. Each item is classified in the same cycle and parked in a
//   two-entry queue.
//   result queue side: while empty is low, out_byte holds the next byte of
//   the encoding and out_last_byte marks its final byte; pop takes it.
//   An item yields 23 to 31 bytes: list header, 0x94, 20 address bytes,
//   then the nonce as an rlp scalar.
//   When the serialiser is free, the first byte shows once the item has
//   passed the queue and been loaded into the shift register. Throughput
//   is one byte per cycle while pop is high, set by the byte serialiser; the
//   next queued item's first byte follows the previous last byte with no gap.
//   When pop stays low the current byte holds and the queue fills; full
//   then rises after two further items.
//   Synchronous reset empties the queue and the serialiser.
module rlp_address_nonce_encoder_core (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        push,
  output logic             full,
  input  wire logic [31:0] in_sender_top,
  input  wire logic [63:0] in_sender_middle,
  input  wire logic [63:0] in_sender_bottom,
  input  wire logic [63:0] in_nonce_value,
  output logic             empty,
  input  wire logic        pop,
  output logic [7:0]       out_byte,
  output logic             out_last_byte
);

  rlpan_pkg::enc_item_t new_item, q_item;
  rlpan_pkg::q_status_t q_status;
  logic                 q_rd;

  rlpan_front u_front (
    .sender_top    (in_sender_top),
    .sender_middle (in_sender_middle),
    .sender_bottom (in_sender_bottom),
    .nonce_value   (in_nonce_value),
    .item          (new_item)
  );

  rlpan_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (push),
    .wr_item (new_item),
    .rd_en   (q_rd),
    .rd_item (q_item),
    .status  (q_status)
  );

  rlpan_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .q_item        (q_item),
    .q_status      (q_status),
    .q_rd          (q_rd),
    .empty         (empty),
    .pop           (pop),
    .out_byte      (out_byte),
    .out_last_byte (out_last_byte)
  );

  assign full = q_status.full;

  a_reset_empty: assert property (@(posedge clk) !rst_n |=> empty)
    else $error("result side not empty after reset");

  a_more_bytes: assert property (@(posedge clk) disable iff (!rst_n)
    (pop && !empty && !out_last_byte) |=> !empty)
    else $error("encoding cut short before its last byte");

  a_reload: assert property (@(posedge clk) disable iff (!rst_n)
    (empty && !q_status.empty) |=> !empty)
    else $error("queued item not picked up by serialiser");

  a_no_read_empty: assert property (@(posedge clk) disable iff (!rst_n)
    q_rd |-> !q_status.empty)
    else $error("serialiser read an empty queue");

endmodule
`default_nettype wire

// ===== tb/rlp_address_nonce_encoder_core_checker.sv =====
// checker for the rlp [sender, nonce] list encoder: watches both queue ports,
// predicts the byte stream of every accepted item and compares it byte by byte
// depends on rlpan_pkg for the rlp prefix constants
`timescale 1ns / 1ps
module rlp_address_nonce_encoder_core_checker (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        push,
  input  wire logic        full,
  input  wire logic [31:0] in_sender_top,
  input  wire logic [63:0] in_sender_middle,
  input  wire logic [63:0] in_sender_bottom,
  input  wire logic [63:0] in_nonce_value,
  input  wire logic        empty,
  input  wire logic        pop,
  input  wire logic [7:0]  out_byte,
  input  wire logic        out_last_byte,
  output int               fail_count,
  output int               pending_bytes
);

  typedef struct {
    logic [7:0] value;
    logic       last;
  } enc_byte_t;

  enc_byte_t expected_bytes[$];

  // builds the whole encoding of one item and queues it
  task automatic predict_encoding(input logic [31:0] s_top, input logic [63:0] s_mid,
                                  input logic [63:0] s_bot, input logic [63:0] nonce);
    logic [7:0]   enc [rlpan_pkg::EncBytes];
    logic [159:0] addr;
    enc_byte_t    eb;
    int           nbytes;
    int           len;
    int           k;
    addr   = {s_top, s_mid, s_bot};
    nbytes = 0;
    for (k = 0; k < 8; k++) begin
      if (nonce[8*k +: 8] != 8'h00) nbytes = k + 1;
    end
    // slot 0 is kept for the list header
    len      = 1;
    enc[len] = rlpan_pkg::AddrPrefix;
    len++;
    for (k = 19; k >= 0; k--) begin
      enc[len] = addr[8*k +: 8];
      len++;
    end
    if (nonce == 64'd0) begin
      enc[len] = rlpan_pkg::StrBase;
      len++;
    end else if (nonce < 64'(rlpan_pkg::StrBase)) begin
      enc[len] = nonce[7:0];
      len++;
    end else begin
      enc[len] = rlpan_pkg::StrBase + 8'(nbytes);
      len++;
      for (k = nbytes - 1; k >= 0; k--) begin
        enc[len] = nonce[8*k +: 8];
        len++;
      end
    end
    // payload length is everything after the list header
    enc[0] = rlpan_pkg::ListBase + 8'(len - 1);
    for (k = 0; k < len; k++) begin
      eb.value = enc[k];
      eb.last  = (k == len - 1);
      expected_bytes.insert(expected_bytes.size(), eb);
    end
  endtask

  always @(posedge clk) begin
    enc_byte_t eb;
    if (!rst_n) begin
      expected_bytes.delete();
    end else begin
      if (push && !full)
        predict_encoding(in_sender_top, in_sender_middle, in_sender_bottom, in_nonce_value);
      if (pop && !empty) begin
        if (expected_bytes.size() == 0) begin
          $display("%0t: unexpected byte: expected none, actual byte %02h last %0b",
                   $time, out_byte, out_last_byte);
          fail_count++;
        end else begin
          eb = expected_bytes.pop_front();
          if (out_byte !== eb.value) begin
            $display("%0t: out_byte: expected %02h, actual %02h", $time, eb.value, out_byte);
            fail_count++;
          end
          if (out_last_byte !== eb.last) begin
            $display("%0t: out_last_byte: expected %0b, actual %0b",
                     $time, eb.last, out_last_byte);
            fail_count++;
          end
        end
      end
    end
    pending_bytes = expected_bytes.size();
  end

endmodule

// ===== tb/rlp_address_nonce_encoder_core_tb.sv =====
// testbench top for rlp_address_nonce_encoder_core: drives directed and random
// sender/nonce items in bursts, stalls the byte output, and gives the verdict
// depends on the encoder rtl and rlp_address_nonce_encoder_core_checker
`timescale 1ns / 1ps
module rlp_address_nonce_encoder_core_tb;

  localparam int RandomItems = 450;
  localparam int IdleLimit   = 5000;
  localparam int DrainCycles = 40;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        push;
  logic        pop = 1'b0;
  logic [31:0] in_sender_top;
  logic [63:0] in_sender_middle;
  logic [63:0] in_sender_bottom;
  logic [63:0] in_nonce_value;
  wire         full;
  wire         empty;
  wire  [7:0]  out_byte;
  wire         out_last_byte;
  int          fail_count;
  int          pending_bytes;
  int          idle_cycles = 0;

  rlp_address_nonce_encoder_core u_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .push             (push),
    .full             (full),
    .in_sender_top    (in_sender_top),
    .in_sender_middle (in_sender_middle),
    .in_sender_bottom (in_sender_bottom),
    .in_nonce_value   (in_nonce_value),
    .empty            (empty),
    .pop              (pop),
    .out_byte         (out_byte),
    .out_last_byte    (out_last_byte)
  );

  rlp_address_nonce_encoder_core_checker u_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .push             (push),
    .full             (full),
    .in_sender_top    (in_sender_top),
    .in_sender_middle (in_sender_middle),
    .in_sender_bottom (in_sender_bottom),
    .in_nonce_value   (in_nonce_value),
    .empty            (empty),
    .pop              (pop),
    .out_byte         (out_byte),
    .out_last_byte    (out_last_byte),
    .fail_count       (fail_count),
    .pending_bytes    (pending_bytes)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // receiver: runs of free popping, random popping and long stalls
  int pop_mode = 0;
  int pop_run  = 0;
  always @(posedge clk) begin
    if (pop_run == 0) begin
      pop_mode = $urandom_range(0, 2);
      pop_run  = $urandom_range(5, 80);
    end else begin
      pop_run--;
    end
    case (pop_mode)
      0: begin
        pop <= 1'b1;
      end
      1: begin
        pop <= 1'($urandom_range(0, 1));
      end
      default: begin
        pop <= ($urandom_range(0, 9) == 0);
      end
    endcase
  end

  always @(posedge clk) begin
    if (!rst_n || (push && !full) || (pop && !empty)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IdleLimit) begin
        $display("rlp_address_nonce_encoder_core: mismatch");
        $finish;
      end
    end
  end

  // holds push high until the item is taken; push stays high afterwards
  task automatic send_item(input logic [31:0] s_top, input logic [63:0] s_mid,
                           input logic [63:0] s_bot, input logic [63:0] nonce);
    push             <= 1'b1;
    in_sender_top    <= s_top;
    in_sender_middle <= s_mid;
    in_sender_bottom <= s_bot;
    in_nonce_value   <= nonce;
    do @(posedge clk); while (full);
  endtask

  task automatic wait_drained();
    do @(posedge clk); while (pending_bytes != 0);
  endtask

  function automatic logic [63:0] random_word();
    return {$urandom, $urandom};
  endfunction

  // nonce of a random byte length, so every encoding length turns up
  function automatic logic [63:0] random_nonce();
    int          nbytes;
    logic [63:0] v;
    nbytes = $urandom_range(0, 8);
    v      = random_word();
    if (nbytes < 8) v = v & ((64'd1 << (8 * nbytes)) - 64'd1);
    return v;
  endfunction

  logic [63:0] directed_nonces[$] = '{
    64'h0, 64'h1, 64'h7f, 64'h80, 64'hff, 64'h100, 64'hffff, 64'h1_0000,
    64'hff_ffff, 64'h100_0000, 64'hffff_ffff, 64'h1_0000_0000, 64'hff_ffff_ffff,
    64'hffff_ffff_ffff, 64'h0100_0000_0000_0000, 64'hffff_ffff_ffff_ffff,
    64'h8000_0000_0000_0000, 64'h0102_0304_0506_0708
  };

  initial begin
    int burst_left;
    int gap;
    rst_n            <= 1'b0;
    push             <= 1'b0;
    in_sender_top    <= '0;
    in_sender_middle <= '0;
    in_sender_bottom <= '0;
    in_nonce_value   <= '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // sender extremes, then every class of nonce with a varied sender
    send_item(32'h0, 64'h0, 64'h0, 64'h0);
    send_item(32'hffff_ffff, 64'hffff_ffff_ffff_ffff, 64'hffff_ffff_ffff_ffff, 64'h0);
    send_item(32'ha5a5_5a5a, 64'h5a5a_a5a5_0f0f_f0f0, 64'h0123_4567_89ab_cdef, 64'h7f);
    foreach (directed_nonces[i])
      send_item($urandom, random_word(), random_word(), directed_nonces[i]);
    send_item(32'hffff_ffff, 64'hffff_ffff_ffff_ffff, 64'hffff_ffff_ffff_ffff,
              64'hffff_ffff_ffff_ffff);
    push <= 1'b0;

    // hold off until the directed bytes have all come out
    wait_drained();

    burst_left = 0;
    for (int n = 0; n < RandomItems; n++) begin
      if (burst_left == 0) begin
        burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(15, 40)
                                                 : $urandom_range(1, 6);
        if (n != 0) begin
          push <= 1'b0;
          gap = $urandom_range(1, 12);
          repeat (gap) @(posedge clk);
        end
      end
      send_item($urandom, random_word(), random_word(), random_nonce());
      burst_left--;
      if (n == RandomItems / 2) begin
        push <= 1'b0;
        wait_drained();
        burst_left = 0;
      end
    end
    push <= 1'b0;

    wait_drained();
    repeat (DrainCycles) @(posedge clk);
    if (fail_count == 0 && pending_bytes == 0) begin
      $display("rlp_address_nonce_encoder_core: match");
    end else begin
      $display("rlp_address_nonce_encoder_core: mismatch");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/core/rlpan_pkg.sv
rtl/core/rlpan_front.sv
rtl/core/rlpan_queue.sv
rtl/core/rlpan_back.sv
rtl/core/rlp_address_nonce_encoder_core.sv
tb/rlp_address_nonce_encoder_core_checker.sv
tb/rlp_address_nonce_encoder_core_tb.sv
